// ===== design/cle_pkg.sv =====
// Shared types and constants for the character LCD expander writer.
package cle_pkg;

	// Line length of the display, in characters.
	localparam int LINE_LENGTH = 16;

	localparam logic [7:0] LINE1_BASE = 8'h80;
	localparam logic [7:0] LINE2_BASE = 8'hC0;
	localparam logic [7:0] CMD_CLEAR  = 8'h01;
	localparam logic [7:0] CMD_HOME   = 8'h02;
	localparam logic [7:0] COUNT_MAX  = 8'hFF;

	// Step numbers within one request. Steps 0 to 7 send a command with the
	// RS drop and raise around it, steps 8 to 13 send a data byte.
	localparam logic [3:0] STEP_CMD_FIRST = 4'd0;
	localparam logic [3:0] STEP_CMD_HI_E  = 4'd2;
	localparam logic [3:0] STEP_CMD_LO    = 4'd4;
	localparam logic [3:0] STEP_CMD_LO_E  = 4'd5;
	localparam logic [3:0] STEP_CMD_LAST  = 4'd7;
	localparam logic [3:0] STEP_DATA      = 4'd8;
	localparam logic [3:0] STEP_DATA_HI_E = 4'd9;
	localparam logic [3:0] STEP_DATA_LO   = 4'd11;
	localparam logic [3:0] STEP_DATA_LO_E = 4'd12;
	localparam logic [3:0] STEP_LAST      = 4'd13;

	typedef enum logic [2:0] {
		REQ_DATA   = 3'd0,
		REQ_CMD    = 3'd1,
		REQ_CLEAR  = 3'd2,
		REQ_HOME   = 3'd3,
		REQ_SETPOS = 3'd4
	} req_t;

	// One request as it is being sent.
	typedef struct packed {
		logic       has_cmd;
		logic       has_data;
		logic [7:0] cmd_byte;
		logic [7:0] data_byte;
	} job_t;

	// One port byte produced by the byte generator.
	typedef struct packed {
		logic [7:0] port_byte;
		logic       last;
	} gen_t;

endpackage

// ===== design/char_lcd_expander_writer_unit.sv =====
// Top level of the character LCD writer that drives a 4-bit LCD through a port expander.
//
//  Channel   Direction  Beat content
//  s_axis    in         tuser: req_type[2:0]; tdata: value[7:0], row[8], column[12:9]
//  m_axis    out        tdata: expander_byte[7:0]; tlast: last byte of a request
//  cfg       in         data: backlight_on
//
// A request yields 6, 8 or 14 port bytes, one per cycle when m_axis is not stalled.
// The step counter of the byte sequencer sets this: while one request occupies it,
// one more request waits in the input register.
// Unknown request types are taken and dropped without output.
// Reset clears the RS level, the character count, the latched nibble and backlight.
// A stall on m_axis holds the output byte and freezes the sequencer.
module char_lcd_expander_writer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // value[7:0], row[8], column[12:9], zero[15:13]
	input  logic [2:0]  s_axis_tuser,  // req_type[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // expander_byte[7:0]
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);

	logic                 pend_valid_s1;
	cle_pkg::req_t        req_s1;
	logic [7:0]           value_s1;
	logic                 row_s1;
	logic [3:0]           column_s1;

	cle_pkg::job_t        job_q;
	logic                 job_valid_q;
	logic [3:0]           step_q;

	logic                 rs_q;
	logic [7:0]           count_q;
	logic [3:0]           nib_q;
	logic                 backlight_q;

	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	logic                 out_last_q;

	logic                 s_accept;
	logic                 type_known;
	logic                 out_free;
	logic                 emit;
	logic                 job_done;
	logic                 load;
	logic                 jump;
	cle_pkg::job_t        job_next;
	logic [3:0]           step_start;
	logic [7:0]           count_next;
	logic [7:0]           pos_base;
	cle_pkg::gen_t        gen;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !pend_valid_s1 || load;
	assign s_accept      = s_axis_tvalid && s_axis_tready;
	assign type_known    = (s_axis_tuser <= 3'(cle_pkg::REQ_SETPOS));

	assign out_free = !out_valid_q || m_axis_tready;
	assign emit     = job_valid_q && out_free;
	assign job_done = emit && gen.last;
	assign load     = pend_valid_s1 && (!job_valid_q || job_done);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tlast  = out_last_q;

	cle_byte_gen u_byte_gen (
		.job       (job_q),
		.step      (step_q),
		.nib_cur   (nib_q),
		.rs_cur    (rs_q),
		.backlight (backlight_q),
		.gen       (gen)
	);

	// Decode the waiting request into the job that the sequencer runs next.
	always_comb begin
		jump       = (req_s1 == cle_pkg::REQ_DATA) &&
			(count_q == 8'(cle_pkg::LINE_LENGTH));
		pos_base   = row_s1 ? cle_pkg::LINE2_BASE : cle_pkg::LINE1_BASE;
		count_next = count_q;
		job_next.has_cmd   = 1'b1;
		job_next.has_data  = 1'b0;
		job_next.data_byte = value_s1;
		unique case (req_s1)
			cle_pkg::REQ_DATA: begin
				job_next.has_cmd  = jump;
				job_next.has_data = 1'b1;
				job_next.cmd_byte = cle_pkg::LINE2_BASE;
				if (count_q != cle_pkg::COUNT_MAX) begin
					count_next = count_q + 8'd1;
				end
			end
			cle_pkg::REQ_CMD: begin
				job_next.cmd_byte = value_s1;
			end
			cle_pkg::REQ_CLEAR: begin
				job_next.cmd_byte = cle_pkg::CMD_CLEAR;
				count_next        = '0;
			end
			cle_pkg::REQ_HOME: begin
				job_next.cmd_byte = cle_pkg::CMD_HOME;
				count_next        = '0;
			end
			cle_pkg::REQ_SETPOS: begin
				job_next.cmd_byte = pos_base + {4'd0, column_s1};
			end
			default: begin
				job_next.cmd_byte = '0;
			end
		endcase
		step_start = job_next.has_cmd ? cle_pkg::STEP_CMD_FIRST : cle_pkg::STEP_DATA;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_s1 <= 1'b0;
			job_valid_q   <= 1'b0;
			step_q        <= '0;
			rs_q          <= 1'b0;
			count_q       <= '0;
			nib_q         <= '0;
			backlight_q   <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				backlight_q <= cfg_data;
			end

			if (s_accept) begin
				pend_valid_s1 <= type_known;
			end else if (load) begin
				pend_valid_s1 <= 1'b0;
			end

			if (load) begin
				job_valid_q <= 1'b1;
				step_q      <= step_start;
				count_q     <= count_next;
			end else if (job_done) begin
				job_valid_q <= 1'b0;
			end else if (emit) begin
				step_q <= step_q + 4'd1;
			end

			if (emit) begin
				rs_q        <= gen.port_byte[0];
				nib_q       <= gen.port_byte[7:4];
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			req_s1    <= cle_pkg::req_t'(s_axis_tuser);
			value_s1  <= s_axis_tdata[7:0];
			row_s1    <= s_axis_tdata[8];
			column_s1 <= s_axis_tdata[12:9];
		end
		if (load) begin
			job_q <= job_next;
		end
		if (emit) begin
			out_byte_q <= gen.port_byte;
			out_last_q <= gen.last;
		end
	end

	a_step_range : assert property (@(posedge clk) disable iff (!arst_n)
		job_valid_q |-> (step_q <= cle_pkg::STEP_LAST))
		else $error("sequencer step beyond the last byte of a request");

	a_rs_raised : assert property (@(posedge clk) disable iff (!arst_n)
		(emit && (step_q == cle_pkg::STEP_CMD_LAST)) |=> rs_q)
		else $error("RS not raised after a command");

	a_pend_kept : assert property (@(posedge clk) disable iff (!arst_n)
		(pend_valid_s1 && !load) |=> pend_valid_s1)
		else $error("waiting request lost");

	a_count_zero : assert property (@(posedge clk) disable iff (!arst_n)
		(load && ((req_s1 == cle_pkg::REQ_CLEAR) || (req_s1 == cle_pkg::REQ_HOME)))
		|=> (count_q == '0))
		else $error("character count not cleared by clear or home");

	a_emit_needs_room : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |-> !emit)
		else $error("byte generated while output stalled");

endmodule

// ===== design/cle_byte_gen.sv =====
// Port byte generator: maps a request and its step number to one expander byte.
module cle_byte_gen (
	input  cle_pkg::job_t job,
	input  logic [3:0]    step,
	input  logic [3:0]    nib_cur,
	input  logic          rs_cur,
	input  logic          backlight,
	output cle_pkg::gen_t gen
);

	logic [3:0] nib;
	logic       e_bit;
	logic       rs_bit;

	always_comb begin
		if (step == cle_pkg::STEP_CMD_FIRST) begin
			// RS drops while the previously latched nibble stays on the port.
			nib    = nib_cur;
			e_bit  = 1'b0;
			rs_bit = 1'b0;
		end else if (step < cle_pkg::STEP_CMD_LO) begin
			nib    = job.cmd_byte[7:4];
			e_bit  = (step == cle_pkg::STEP_CMD_HI_E);
			rs_bit = 1'b0;
		end else if (step < cle_pkg::STEP_CMD_LAST) begin
			nib    = job.cmd_byte[3:0];
			e_bit  = (step == cle_pkg::STEP_CMD_LO_E);
			rs_bit = 1'b0;
		end else if (step == cle_pkg::STEP_CMD_LAST) begin
			nib    = job.cmd_byte[3:0];
			e_bit  = 1'b0;
			rs_bit = 1'b1;
		end else if (step < cle_pkg::STEP_DATA_LO) begin
			nib    = job.data_byte[7:4];
			e_bit  = (step == cle_pkg::STEP_DATA_HI_E);
			rs_bit = rs_cur;
		end else begin
			nib    = job.data_byte[3:0];
			e_bit  = (step == cle_pkg::STEP_DATA_LO_E);
			rs_bit = rs_cur;
		end
		gen.port_byte = {nib, backlight, e_bit, 1'b0, rs_bit};
		gen.last      = (step == cle_pkg::STEP_LAST) ||
			((step == cle_pkg::STEP_CMD_LAST) && !job.has_data);
	end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the character LCD expander writer, with its own model of the bytes.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LONG_HOLD      = 400;
	localparam int DRAIN_CYCLES   = 32;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PRINT_LIMIT    = 50;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] value;
		logic       row;
		logic [3:0] column;
	} lcd_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;   // value[7:0], row[8], column[12:9], zero[15:13]
	logic [2:0]  s_axis_tuser = '0;   // req_type[2:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;        // expander_byte[7:0]
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data = 1'b0;

	lcd_req_t       lcd_reqs_pending[$];
	lcd_req_t       offered;
	cle_pkg::gen_t  port_bytes_due[$];

	// Predicted display state.
	logic        lcd_rs = 1'b0;
	logic [7:0]  chars_written = '0;
	logic [3:0]  latched_nibble = '0;
	logic        backlight = 1'b0;

	bit          tx_gaps = 1'b1;
	bit          rx_gaps = 1'b1;
	int unsigned tx_gap;
	int unsigned rx_stall;
	int          holds_asked = 0;
	int          holds_done;
	int          quiet_cycles = 0;
	int          mismatches = 0;

	char_lcd_expander_writer_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < PRINT_LIMIT) begin
			$display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
		end
		mismatches++;
	endtask

	// Mostly back to back, sometimes a few cycles, now and then a long pause.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	task automatic emit_port_byte(input logic e_bit);
		cle_pkg::gen_t b;
		b.port_byte = {latched_nibble, backlight, e_bit, 1'b0, lcd_rs};
		b.last      = 1'b0;
		port_bytes_due.push_back(b);
	endtask

	task automatic strobe_nibble(input logic [3:0] nib);
		latched_nibble = nib;
		emit_port_byte(1'b0);
		emit_port_byte(1'b1);
		emit_port_byte(1'b0);
	endtask

	task automatic strobe_byte(input logic [7:0] v);
		strobe_nibble(v[7:4]);
		strobe_nibble(v[3:0]);
	endtask

	// RS drops for the command and is left high afterwards.
	task automatic send_lcd_command(input logic [7:0] v);
		lcd_rs = 1'b0;
		emit_port_byte(1'b0);
		strobe_byte(v);
		lcd_rs = 1'b1;
		emit_port_byte(1'b0);
	endtask

	task automatic predict_port_bytes(input lcd_req_t r);
		int            first;
		cle_pkg::gen_t tail;
		first = port_bytes_due.size();
		case (r.kind)
			cle_pkg::REQ_DATA: begin
				// The wrap to the second line fires only on an exact count match.
				if (chars_written == cle_pkg::LINE_LENGTH) begin
					send_lcd_command(cle_pkg::LINE2_BASE);
				end
				if (chars_written != cle_pkg::COUNT_MAX) begin
					chars_written = chars_written + 8'd1;
				end
				strobe_byte(r.value);
			end
			cle_pkg::REQ_CMD: begin
				send_lcd_command(r.value);
			end
			cle_pkg::REQ_CLEAR: begin
				send_lcd_command(cle_pkg::CMD_CLEAR);
				chars_written = '0;
			end
			cle_pkg::REQ_HOME: begin
				send_lcd_command(cle_pkg::CMD_HOME);
				chars_written = '0;
			end
			cle_pkg::REQ_SETPOS: begin
				send_lcd_command((r.row ? cle_pkg::LINE2_BASE : cle_pkg::LINE1_BASE)
					+ {4'h0, r.column});
			end
			default: begin
			end
		endcase
		if (port_bytes_due.size() > first) begin
			tail = port_bytes_due.pop_back();
			tail.last = 1'b1;
			port_bytes_due.push_back(tail);
		end
	endtask

	task automatic queue_req(input logic [2:0] kind, input logic [7:0] value,
			input logic row, input logic [3:0] column);
		lcd_req_t r;
		r.kind   = kind;
		r.value  = value;
		r.row    = row;
		r.column = column;
		lcd_reqs_pending.push_back(r);
	endtask

	task automatic queue_char();
		queue_req(cle_pkg::REQ_DATA, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			4'($urandom_range(0, 15)));
	endtask

	// Requests that leave the character count alone.
	task automatic queue_noise();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			queue_req(cle_pkg::REQ_CMD, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				4'($urandom_range(0, 15)));
		end else if (r < 70) begin
			queue_req(cle_pkg::REQ_SETPOS, 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
		end else begin
			queue_req(3'($urandom_range(5, 7)), 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
		end
	endtask

	// Characters with an occasional other request; returns once enough characters are queued.
	task automatic queue_text(input int n_chars, input int noise_one_in);
		int sent;
		sent = 0;
		while (sent < n_chars) begin
			if ($urandom_range(1, noise_one_in) == 1) begin
				queue_noise();
			end else begin
				queue_char();
				sent++;
			end
		end
	endtask

	// Dropped request types give no beat, so the wait runs on for a drain period once the last byte is in.
	task automatic wait_until_drained();
		do @(posedge clk);
		while (lcd_reqs_pending.size() != 0 || s_axis_tvalid || port_bytes_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_backlight(input logic v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		backlight = v;
	endtask

	always @(posedge clk or negedge arst_n) begin : tx_side
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
			tx_gap        <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_port_bytes(offered);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (tx_gap != 0) begin
					tx_gap        <= tx_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (lcd_reqs_pending.size() != 0) begin
					offered = lcd_reqs_pending.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {3'b000, offered.column, offered.row, offered.value};
					s_axis_tuser  <= offered.kind;
					tx_gap        <= tx_gaps ? pick_gap() : 0;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : rx_side
		int unsigned gap;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_stall      <= 0;
			holds_done    <= 0;
		end else if (rx_stall != 0) begin
			rx_stall      <= rx_stall - 1;
			m_axis_tready <= 1'b0;
		end else if (holds_done != holds_asked) begin
			// Long hold-off so the block backs up and stops taking requests.
			holds_done    <= holds_done + 1;
			rx_stall      <= LONG_HOLD;
			m_axis_tready <= 1'b0;
		end else if (!rx_gaps) begin
			m_axis_tready <= 1'b1;
		end else begin
			gap = pick_gap();
			m_axis_tready <= (gap == 0);
			rx_stall      <= (gap == 0) ? 0 : gap - 1;
		end
	end

	always @(posedge clk) begin : port_monitor
		cle_pkg::gen_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (port_bytes_due.size() == 0) begin
				report_mismatch("port byte with nothing due", int'(m_axis_tdata), 0);
			end else begin
				want = port_bytes_due.pop_front();
				if (m_axis_tdata !== want.port_byte) begin
					report_mismatch("expander byte", int'(m_axis_tdata), int'(want.port_byte));
				end
				if (m_axis_tlast !== want.last) begin
					report_mismatch("last flag", int'(m_axis_tlast), int'(want.last));
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("Timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : sequencer
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed requests, backlight off. The first character goes out before any command.
		write_backlight(1'b0);
		queue_req(cle_pkg::REQ_DATA, 8'h00, 1'b0, 4'h0);
		queue_req(cle_pkg::REQ_DATA, 8'hFF, 1'b1, 4'hF);
		queue_req(cle_pkg::REQ_CMD, 8'h00, 1'b0, 4'h0);
		queue_req(cle_pkg::REQ_CMD, 8'hFF, 1'b1, 4'hF);
		queue_req(cle_pkg::REQ_DATA, 8'hA5, 1'b0, 4'h5);
		queue_req(cle_pkg::REQ_CLEAR, 8'h3C, 1'b1, 4'h9);
		queue_req(cle_pkg::REQ_HOME, 8'hC3, 1'b0, 4'h6);
		queue_req(cle_pkg::REQ_SETPOS, 8'h00, 1'b0, 4'h0);
		queue_req(cle_pkg::REQ_SETPOS, 8'hFF, 1'b1, 4'hF);
		queue_req(cle_pkg::REQ_SETPOS, 8'h11, 1'b0, 4'hF);
		queue_req(cle_pkg::REQ_SETPOS, 8'hEE, 1'b1, 4'h0);
		queue_req(3'd5, 8'hFF, 1'b1, 4'hF);
		queue_req(3'd6, 8'h00, 1'b0, 4'h0);
		queue_req(3'd7, 8'($urandom_range(0, 255)), 1'b1, 4'($urandom_range(0, 15)));
		queue_req(cle_pkg::REQ_DATA, 8'h5A, 1'b1, 4'hA);
		queue_req(cle_pkg::REQ_CMD, 8'h01, 1'b0, 4'h3);
		wait_until_drained();

		// Two long runs from one clear: they pass the line wrap and push the count to its top.
		write_backlight(1'b1);
		queue_req(cle_pkg::REQ_CLEAR, 8'h00, 1'b0, 4'h0);
		queue_text(128, 25);
		holds_asked = holds_asked + 1;
		wait_until_drained();

		write_backlight(1'b0);
		queue_text(128, 25);
		wait_until_drained();

		// A short screen without any idling.
		write_backlight(1'b1);
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		queue_req($urandom_range(0, 1) ? cle_pkg::REQ_CLEAR : cle_pkg::REQ_HOME,
			8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
		queue_text($urandom_range(12, 20), 8);
		wait_until_drained();

		write_backlight(1'b0);
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		queue_req($urandom_range(0, 1) ? cle_pkg::REQ_CLEAR : cle_pkg::REQ_HOME,
			8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
		queue_text($urandom_range(12, 20), 8);
		wait_until_drained();

		if (port_bytes_due.size() != 0) begin
			report_mismatch("port bytes never sent", 0, port_bytes_due.size());
		end
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
